/* src/rtcp_sdes_item_extractor_macros.svh */
// Assertion macros shared by the checker of the SDES item extractor.
// Each macro expects signals named clk and rst_n in the scope where it is used.
`ifndef RTCP_SDES_ITEM_EXTRACTOR_MACROS_SVH
`define RTCP_SDES_ITEM_EXTRACTOR_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define RSIE_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define RSIE_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* src/rsie_pkg.sv */
// Types and constants of the RTCP SDES item extractor.
// Used by the parser, the result queue and the top level; depends on nothing.
package rsie_pkg;

  localparam logic [7:0] SDES_TYPE   = 8'd202;
  localparam logic [7:0] ITEM_END    = 8'd0;
  localparam logic [1:0] VER_ONE     = 2'd1;
  localparam logic [1:0] VER_TWO     = 2'd2;
  localparam int         FIFO_DEPTH  = 4;
  localparam int         PTR_W       = 2;
  localparam int         CNT_W       = 3;
  localparam logic [CNT_W-1:0] ROOM_MAX = CNT_W'(FIFO_DEPTH - 2);

  typedef enum logic [3:0] {
    PH_HDR0    = 4'd0,
    PH_HDR1    = 4'd1,
    PH_HDR2    = 4'd2,
    PH_HDR3    = 4'd3,
    PH_SKIPSUB = 4'd4,
    PH_SSRC    = 4'd5,
    PH_ITYPE   = 4'd6,
    PH_ILEN    = 4'd7,
    PH_ISKIP   = 4'd8,
    PH_BODY    = 4'd9,
    PH_IDLE    = 4'd10
  } phase_t;

  typedef struct packed {
    logic [7:0] text_byte;
    logic       text_last;
    logic       is_summary;
    logic       found;
  } result_t;

  typedef struct packed {
    logic    text_vld;
    logic    sum_vld;
    result_t text;
    result_t sum;
  } push_t;

endpackage

/* src/rsie_if.sv */
// Handshake channels of the RTCP SDES item extractor: input, result and configuration.
// Depends on nothing.
interface rsie_in_if;
  logic        valid;
  logic        ready;
  logic [7:0]  pkt_byte;
  logic [12:0] pkt_len;
  logic        byte_last;
  modport source (output valid, pkt_byte, pkt_len, byte_last, input ready);
  modport sink (input valid, pkt_byte, pkt_len, byte_last, output ready);
endinterface

interface rsie_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] text_byte;
  logic       text_last;
  logic       is_summary;
  logic       found;
  modport source (output valid, text_byte, text_last, is_summary, found, input ready);
  modport sink (input valid, text_byte, text_last, is_summary, found, output ready);
endinterface

interface rsie_cfg_if;
  logic       valid;
  logic       ready;
  logic [7:0] wanted_item_type;
  modport source (output valid, wanted_item_type, input ready);
  modport sink (input valid, wanted_item_type, output ready);
endinterface

/* src/rsie_parser.sv */
// Input register and per-byte subpacket/item walker of the SDES item extractor.
// Depends on rsie_pkg and the input channel interface.
module rsie_parser #(
  parameter int MAX_PACKET_BYTES = 4096
) (
  input  logic                clk,
  input  logic                rst_n,
  rsie_in_if.sink             in_ch,
  input  logic [7:0]          wanted_type,
  input  logic                room,
  output rsie_pkg::push_t     push
);

  localparam int OFF_W = $clog2(MAX_PACKET_BYTES + 1);
  localparam int SE_W  = $clog2(MAX_PACKET_BYTES + 262145);
  localparam int IE_W  = $clog2(MAX_PACKET_BYTES + 257);
  localparam int CW    = SE_W + 1;
  localparam logic [CW-1:0]    MAX_W   = CW'(MAX_PACKET_BYTES);
  localparam logic [OFF_W-1:0] MAX_OFF = OFF_W'(MAX_PACKET_BYTES);

  logic              in_v_r;
  logic [7:0]        byte_r;
  logic [12:0]       len_r;
  logic              last_r;
  logic              fire;

  logic [OFF_W-1:0]  off_r, off_nxt;
  logic [SE_W-1:0]   se_r, se_nxt;
  logic [IE_W-1:0]   ie_r, ie_nxt;
  rsie_pkg::phase_t  ph_r, ph_nxt;
  logic [7:0]        hfb_r, hfb_nxt;
  logic [7:0]        typ_r, typ_nxt;
  logic              found_r, found_nxt;
  logic              stop_r, stop_nxt;

  logic [CW-1:0]     off_w, eff, b_w, se_w, ie_w, start_w, end_w, ie_calc;
  logic [15:0]       words;
  logic              tl;

  assign fire     = in_v_r && room;
  assign in_ch.ready = !in_v_r || fire;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r <= 1'b0;
    end else if (in_ch.ready) begin
      in_v_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.ready && in_ch.valid) begin
      byte_r <= in_ch.pkt_byte;
      len_r  <= in_ch.pkt_len;
      last_r <= in_ch.byte_last;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      off_r   <= '0;
      se_r    <= '0;
      ie_r    <= '0;
      ph_r    <= rsie_pkg::PH_HDR0;
      hfb_r   <= '0;
      typ_r   <= '0;
      found_r <= 1'b0;
      stop_r  <= 1'b0;
    end else begin
      off_r   <= off_nxt;
      se_r    <= se_nxt;
      ie_r    <= ie_nxt;
      ph_r    <= ph_nxt;
      hfb_r   <= hfb_nxt;
      typ_r   <= typ_nxt;
      found_r <= found_nxt;
      stop_r  <= stop_nxt;
    end
  end

  always_comb begin
    off_w   = CW'(off_r);
    eff     = (CW'(len_r) > MAX_W) ? MAX_W : CW'(len_r);
    b_w     = CW'(byte_r);
    se_w    = CW'(se_r);
    ie_w    = CW'(ie_r);
    words   = {se_r[7:0], byte_r};
    start_w = off_w - CW'(3);
    end_w   = start_w + ((CW'(words) + CW'(1)) << 2);
    ie_calc = off_w + CW'(1) + b_w;
    tl      = (off_w + CW'(1)) >= ie_w;

    off_nxt   = off_r;
    se_nxt    = se_r;
    ie_nxt    = ie_r;
    ph_nxt    = ph_r;
    hfb_nxt   = hfb_r;
    typ_nxt   = typ_r;
    found_nxt = found_r;
    stop_nxt  = stop_r;

    push           = '0;
    push.sum.is_summary = 1'b1;

    if (fire && (off_w < eff) && !stop_r) begin
      case (ph_r)
        rsie_pkg::PH_HDR0: begin
          if (((off_w + CW'(4)) > eff) ||
              !(byte_r[7:6] inside {rsie_pkg::VER_ONE, rsie_pkg::VER_TWO})) begin
            stop_nxt = 1'b1;
            ph_nxt   = rsie_pkg::PH_IDLE;
          end else begin
            hfb_nxt = byte_r;
            ph_nxt  = rsie_pkg::PH_HDR1;
          end
        end
        rsie_pkg::PH_HDR1: begin
          typ_nxt = byte_r;
          ph_nxt  = rsie_pkg::PH_HDR2;
        end
        rsie_pkg::PH_HDR2: begin
          se_nxt = SE_W'(byte_r);
          ph_nxt = rsie_pkg::PH_HDR3;
        end
        rsie_pkg::PH_HDR3: begin
          se_nxt = SE_W'(end_w);
          if (end_w > eff) begin
            stop_nxt = 1'b1;
            ph_nxt   = rsie_pkg::PH_IDLE;
          end else if ((typ_r == rsie_pkg::SDES_TYPE) && (hfb_r[4:0] != 5'd0)) begin
            if ((start_w + CW'(10)) > end_w) begin
              stop_nxt = 1'b1;
              ph_nxt   = rsie_pkg::PH_IDLE;
            end else begin
              ie_nxt = IE_W'(start_w + CW'(8));
              ph_nxt = rsie_pkg::PH_SSRC;
            end
          end else if ((off_w + CW'(1)) == end_w) begin
            ph_nxt = rsie_pkg::PH_HDR0;
          end else begin
            ph_nxt = rsie_pkg::PH_SKIPSUB;
          end
        end
        rsie_pkg::PH_SKIPSUB: begin
          if ((off_w + CW'(1)) >= se_w) begin
            ph_nxt = rsie_pkg::PH_HDR0;
          end
        end
        rsie_pkg::PH_SSRC: begin
          if (tl) begin
            ph_nxt = rsie_pkg::PH_ITYPE;
          end
        end
        rsie_pkg::PH_ITYPE: begin
          if (byte_r == rsie_pkg::ITEM_END) begin
            stop_nxt = 1'b1;
            ph_nxt   = rsie_pkg::PH_IDLE;
          end else begin
            typ_nxt = byte_r;
            ph_nxt  = rsie_pkg::PH_ILEN;
          end
        end
        rsie_pkg::PH_ILEN: begin
          ie_nxt = IE_W'(ie_calc);
          if (ie_calc > se_w) begin
            stop_nxt = 1'b1;
            ph_nxt   = rsie_pkg::PH_IDLE;
          end else if (typ_r == wanted_type) begin
            found_nxt = 1'b1;
            if (byte_r == 8'd0) begin
              stop_nxt = 1'b1;
              ph_nxt   = rsie_pkg::PH_IDLE;
            end else begin
              ph_nxt = rsie_pkg::PH_BODY;
            end
          end else if (byte_r == 8'd0) begin
            if ((ie_calc + CW'(2)) <= se_w) begin
              ph_nxt = rsie_pkg::PH_ITYPE;
            end else begin
              stop_nxt = 1'b1;
              ph_nxt   = rsie_pkg::PH_IDLE;
            end
          end else begin
            ph_nxt = rsie_pkg::PH_ISKIP;
          end
        end
        rsie_pkg::PH_ISKIP: begin
          if (tl) begin
            if ((ie_w + CW'(2)) <= se_w) begin
              ph_nxt = rsie_pkg::PH_ITYPE;
            end else begin
              stop_nxt = 1'b1;
              ph_nxt   = rsie_pkg::PH_IDLE;
            end
          end
        end
        rsie_pkg::PH_BODY: begin
          push.text_vld       = 1'b1;
          push.text.text_byte = byte_r;
          push.text.text_last = tl;
          if (tl) begin
            stop_nxt = 1'b1;
            ph_nxt   = rsie_pkg::PH_IDLE;
          end
        end
        default: begin
          stop_nxt = 1'b1;
          ph_nxt   = rsie_pkg::PH_IDLE;
        end
      endcase
    end

    if (fire && (off_r != MAX_OFF)) begin
      off_nxt = off_r + OFF_W'(1);
    end

    if (fire && last_r) begin
      push.sum_vld   = 1'b1;
      push.sum.found = found_nxt;
      off_nxt   = '0;
      se_nxt    = '0;
      ie_nxt    = '0;
      ph_nxt    = rsie_pkg::PH_HDR0;
      hfb_nxt   = '0;
      typ_nxt   = '0;
      found_nxt = 1'b0;
      stop_nxt  = 1'b0;
    end
  end

endmodule

/* src/rsie_out_fifo.sv */
// Four-word result queue of the SDES item extractor; takes up to two words per cycle.
// Depends on rsie_pkg and the result channel interface.
module rsie_out_fifo (
  input  logic            clk,
  input  logic            rst_n,
  input  rsie_pkg::push_t push,
  output logic            room,
  rsie_out_if.source      out_ch
);

  rsie_pkg::result_t                  mem [rsie_pkg::FIFO_DEPTH];
  logic [rsie_pkg::PTR_W-1:0]         wp_r, wp_nxt, rp_r, rp_nxt, wp_sum;
  logic [rsie_pkg::CNT_W-1:0]         cnt_r, cnt_nxt;
  logic                               pop;
  rsie_pkg::result_t                  head;

  assign room   = cnt_r <= rsie_pkg::ROOM_MAX;
  assign pop    = out_ch.valid && out_ch.ready;
  assign wp_sum = wp_r + rsie_pkg::PTR_W'(push.text_vld);

  always_comb begin
    head              = mem[rp_r];
    out_ch.valid      = cnt_r != '0;
    out_ch.text_byte  = head.text_byte;
    out_ch.text_last  = head.text_last;
    out_ch.is_summary = head.is_summary;
    out_ch.found      = head.found;
    wp_nxt  = wp_sum + rsie_pkg::PTR_W'(push.sum_vld);
    rp_nxt  = rp_r + rsie_pkg::PTR_W'(pop);
    cnt_nxt = cnt_r + rsie_pkg::CNT_W'(push.text_vld) + rsie_pkg::CNT_W'(push.sum_vld)
              - rsie_pkg::CNT_W'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push.text_vld) begin
      mem[wp_r] <= push.text;
    end
    if (push.sum_vld) begin
      mem[wp_sum] <= push.sum;
    end
  end

endmodule

/* src/rtcp_sdes_item_extractor.sv */
// Top level of the RTCP SDES item extractor: holds the wanted-type register and
// connects the byte parser to the result queue. Depends on rsie_pkg and rsie_if.
//
// Usage: datagram bytes enter on in_ch, one word per byte, with the datagram
// length on every word and byte_last on the final one. Words leave on out_ch:
// the text bytes of the first SDES item of the first chunk with the wanted type,
// the last one marked by text_last, and then one summary word (is_summary set)
// carrying the found flag at the end of each datagram. cfg_ch writes the wanted
// item type; it is always ready and is meant to be written between datagrams.
// Throughput is one byte per cycle while the result queue has room, limited by
// the single parse step per byte. A result passes through the input register
// and then the four-word result queue before it appears on out_ch. A final byte
// that also ends the text yields two words, which the queue absorbs. When the
// receiver stalls, the queue fills and in_ch.ready drops once fewer than two
// free entries remain. Synchronous reset empties the queue and input register,
// returns the parser to expect a subpacket header and sets the type to 2.
module rtcp_sdes_item_extractor #(
  parameter int MAX_PACKET_BYTES = 4096
) (
  input  logic        clk,
  input  logic        rst_n,
  rsie_in_if.sink     in_ch,
  rsie_out_if.source  out_ch,
  rsie_cfg_if.sink    cfg_ch
);

  logic [7:0]      wanted_r;
  logic            room;
  rsie_pkg::push_t push;

  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wanted_r <= 8'd2;
    end else if (cfg_ch.valid) begin
      wanted_r <= cfg_ch.wanted_item_type;
    end
  end

  rsie_parser #(
    .MAX_PACKET_BYTES(MAX_PACKET_BYTES)
  ) u_parser (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_ch       (in_ch),
    .wanted_type (wanted_r),
    .room        (room),
    .push        (push)
  );

  rsie_out_fifo u_out_fifo (
    .clk    (clk),
    .rst_n  (rst_n),
    .push   (push),
    .room   (room),
    .out_ch (out_ch)
  );

endmodule

/* src/rsie_checker.sv */
// Port-level assertions for the SDES item extractor and the bind that attaches them.
// Depends on rtcp_sdes_item_extractor_macros.svh.
`include "rtcp_sdes_item_extractor_macros.svh"

module rsie_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] text_byte,
  input logic       text_last,
  input logic       is_summary,
  input logic       found
);

  logic [10:0] word;
  logic        stall;
  logic        text_clear;
  logic        last_taken;

  assign word       = {text_byte, text_last, is_summary, found};
  assign stall      = out_valid && !out_ready;
  assign text_clear = (text_byte == 8'd0) && !text_last;
  assign last_taken = out_valid && out_ready && !is_summary && text_last;

  `RSIE_ASSERT_NEXT(a_out_hold, stall, out_valid && $stable(word), "stalled result word changed")
  `RSIE_ASSERT_SAME(a_text_no_found, out_valid && !is_summary, !found, "text word carries found")
  `RSIE_ASSERT_SAME(a_sum_clean, out_valid && is_summary, text_clear, "summary word carries text")
  `RSIE_ASSERT_NEXT(a_last_then_sum, last_taken, !out_valid || is_summary, "text after last byte")

endmodule

bind rtcp_sdes_item_extractor rsie_checker u_rsie_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_valid  (out_ch.valid),
  .out_ready  (out_ch.ready),
  .text_byte  (out_ch.text_byte),
  .text_last  (out_ch.text_last),
  .is_summary (out_ch.is_summary),
  .found      (out_ch.found)
);

/* tb/sv/rtcp_sdes_item_extractor_tb.sv */
`timescale 1ns / 100ps
// Self-checking testbench of the RTCP SDES item extractor: drives compound datagrams
// byte by byte, predicts the text and summary words and checks them as they leave.
// Depends on rsie_pkg, the rsie interfaces and the rtcp_sdes_item_extractor top level.
module rtcp_sdes_item_extractor_tb;

  localparam int MAX_BYTES = 4096;
  localparam int WATCHDOG_LIMIT = 1000;
  localparam int DRAIN_SETTLE = 4;
  localparam int END_SETTLE = 10;
  localparam int RANDOM_PHASES = 4;
  localparam int PHASE_BYTES = 20;

  localparam logic [7:0] PT_SR = 8'd200;
  localparam logic [7:0] PT_RR = 8'd201;
  localparam logic [7:0] PT_BYE = 8'd203;
  localparam logic [7:0] PT_APP = 8'd204;

  typedef enum int {
    LEN_EXACT,
    LEN_SHORT,
    LEN_LONG,
    LEN_EARLY_LAST,
    LEN_TRAILING,
    LEN_WOBBLE
  } len_mode_t;

  class sdes_text_scoreboard_t;
    bit [7:0] wanted_type;
    int offs;
    int sub_end;
    int itm_end;
    rsie_pkg::phase_t phase;
    bit [7:0] hdr_first;
    bit [7:0] type_held;
    bit copying;
    bit found_f;
    bit stopped;
    rsie_pkg::result_t expected_words[$];
    int errors;

    function new();
      wanted_type = 8'd2;
      errors = 0;
      clear();
    endfunction

    function void clear();
      offs = 0;
      sub_end = 0;
      itm_end = 0;
      phase = rsie_pkg::PH_HDR0;
      hdr_first = 8'd0;
      type_held = 8'd0;
      copying = 1'b0;
      found_f = 1'b0;
      stopped = 1'b0;
    endfunction

    function void halt();
      stopped = 1'b1;
      copying = 1'b0;
      phase = rsie_pkg::PH_IDLE;
    endfunction

    function void advance_item();
      if (itm_end + 2 <= sub_end) begin
        phase = rsie_pkg::PH_ITYPE;
      end else begin
        halt();
      end
    endfunction

    function void note_byte(bit [7:0] b, bit [12:0] len, bit last);
      int eff;
      int off;
      int words;
      int start;
      int fin;
      bit [1:0] ver;
      rsie_pkg::result_t w;
      eff = (len > MAX_BYTES) ? MAX_BYTES : int'(len);
      off = offs;
      if (off < eff && !stopped) begin
        case (phase)
          rsie_pkg::PH_HDR0: begin
            ver = b[7:6];
            if (off + 4 > eff || !(ver inside {rsie_pkg::VER_ONE, rsie_pkg::VER_TWO})) begin
              halt();
            end else begin
              hdr_first = b;
              phase = rsie_pkg::PH_HDR1;
            end
          end
          rsie_pkg::PH_HDR1: begin
            type_held = b;
            phase = rsie_pkg::PH_HDR2;
          end
          rsie_pkg::PH_HDR2: begin
            sub_end = b;
            phase = rsie_pkg::PH_HDR3;
          end
          rsie_pkg::PH_HDR3: begin
            words = ((sub_end & 'hFF) << 8) | b;
            start = off - 3;
            fin = start + (words + 1) * 4;
            sub_end = fin & 'h7FFFF;
            if (fin > eff) begin
              halt();
            end else if (type_held == rsie_pkg::SDES_TYPE && hdr_first[4:0] != 5'd0) begin
              if (start + 10 > fin) begin
                halt();
              end else begin
                itm_end = start + 8;
                phase = rsie_pkg::PH_SSRC;
              end
            end else if (off + 1 == fin) begin
              phase = rsie_pkg::PH_HDR0;
            end else begin
              phase = rsie_pkg::PH_SKIPSUB;
            end
          end
          rsie_pkg::PH_SKIPSUB: begin
            if (off + 1 >= sub_end) phase = rsie_pkg::PH_HDR0;
          end
          rsie_pkg::PH_SSRC: begin
            if (off + 1 >= itm_end) phase = rsie_pkg::PH_ITYPE;
          end
          rsie_pkg::PH_ITYPE: begin
            if (b == rsie_pkg::ITEM_END) begin
              halt();
            end else begin
              type_held = b;
              phase = rsie_pkg::PH_ILEN;
            end
          end
          rsie_pkg::PH_ILEN: begin
            itm_end = off + 1 + b;
            if (itm_end > sub_end) begin
              halt();
            end else if (type_held == wanted_type) begin
              found_f = 1'b1;
              if (b == 8'd0) begin
                halt();
              end else begin
                copying = 1'b1;
                phase = rsie_pkg::PH_BODY;
              end
            end else if (b == 8'd0) begin
              advance_item();
            end else begin
              phase = rsie_pkg::PH_ISKIP;
            end
          end
          rsie_pkg::PH_ISKIP: begin
            if (off + 1 >= itm_end) advance_item();
          end
          rsie_pkg::PH_BODY: begin
            w = '{text_byte: b, text_last: (off + 1 >= itm_end), is_summary: 1'b0,
                  found: 1'b0};
            expected_words.push_back(w);
            if (w.text_last) halt();
          end
          default: begin
            halt();
          end
        endcase
      end
      if (offs < MAX_BYTES) offs++;
      if (last) begin
        w = '{text_byte: 8'h00, text_last: 1'b0, is_summary: 1'b1, found: found_f};
        expected_words.push_back(w);
        clear();
      end
    endfunction

    function void check_word(logic [7:0] text_byte, logic text_last, logic is_summary,
                             logic found);
      rsie_pkg::result_t exp_w;
      if (expected_words.size() == 0) begin
        errors++;
        $display("%0t: unexpected word text_byte=%h text_last=%b is_summary=%b found=%b",
                 $time, text_byte, text_last, is_summary, found);
        return;
      end
      exp_w = expected_words.pop_front();
      if (text_byte !== exp_w.text_byte) begin
        errors++;
        $display("%0t: text_byte expected %h actual %h", $time, exp_w.text_byte, text_byte);
      end
      if (text_last !== exp_w.text_last) begin
        errors++;
        $display("%0t: text_last expected %b actual %b", $time, exp_w.text_last, text_last);
      end
      if (is_summary !== exp_w.is_summary) begin
        errors++;
        $display("%0t: is_summary expected %b actual %b", $time, exp_w.is_summary,
                 is_summary);
      end
      if (found !== exp_w.found) begin
        errors++;
        $display("%0t: found expected %b actual %b", $time, exp_w.found, found);
      end
    endfunction
  endclass

  logic clk;
  logic rst_n;
  bit in_gaps_on;
  bit out_gaps_on;
  bit [7:0] dgram_bytes[$];
  int random_bytes;
  sdes_text_scoreboard_t sb = new();

  rsie_in_if in_ch();
  rsie_out_if out_ch();
  rsie_cfg_if cfg_ch();

  rtcp_sdes_item_extractor #(
    .MAX_PACKET_BYTES(MAX_BYTES)
  ) i_dut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .out_ch(out_ch),
    .cfg_ch(cfg_ch)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    out_ch.ready <= 1'b0;
    wait (rst_n === 1'b1);
    @(negedge clk);
    forever begin
      int gap;
      gap = out_gaps_on ? $urandom_range(0, 16) : 0;
      if (gap > 0) begin
        out_ch.ready <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (!out_ch.valid);
      @(negedge clk);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) begin
      sb.check_word(out_ch.text_byte, out_ch.text_last, out_ch.is_summary, out_ch.found);
    end
  end

  initial begin : watchdog
    int idle_cycles;
    idle_cycles = 0;
    wait (rst_n === 1'b1);
    while (idle_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
          (cfg_ch.valid && cfg_ch.ready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
    end
    $display("%0t: no word moved for %0d cycles", $time, WATCHDOG_LIMIT);
    $display("Test completed with failures");
    $finish;
  end

  task automatic push_byte(bit [7:0] b, bit [12:0] len, bit last);
    int gap;
    gap = in_gaps_on ? $urandom_range(0, 16) : 0;
    @(negedge clk);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.pkt_byte <= b;
    in_ch.pkt_len <= len;
    in_ch.byte_last <= last;
    do @(posedge clk); while (!in_ch.ready);
    sb.note_byte(b, len, last);
  endtask

  task automatic send_datagram(int len_field, int last_at, bit wobble);
    int len;
    for (int i = 0; i <= last_at; i++) begin
      len = len_field;
      if (wobble) begin
        len = len_field - 3 + $urandom_range(0, 6);
        if (len < 0) len = 0;
      end
      push_byte(dgram_bytes[i], 13'(len), i == last_at);
    end
  endtask

  task automatic send_whole();
    send_datagram(dgram_bytes.size(), dgram_bytes.size() - 1, 1'b0);
  endtask

  task automatic await_drain();
    @(negedge clk);
    in_ch.valid <= 1'b0;
    while (sb.expected_words.size() != 0) @(posedge clk);
    repeat (DRAIN_SETTLE) @(posedge clk);
  endtask

  task automatic write_wanted_type(bit [7:0] t);
    await_drain();
    @(negedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.wanted_item_type <= t;
    do @(posedge clk); while (!cfg_ch.ready);
    sb.wanted_type = t;
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
  endtask

  function automatic void add_skip_subpacket();
    bit [7:0] ptype;
    bit [7:0] hdr;
    int nw;
    case ($urandom_range(0, 4))
      0: ptype = PT_SR;
      1: ptype = PT_RR;
      2: ptype = PT_BYE;
      3: ptype = PT_APP;
      default: ptype = rsie_pkg::SDES_TYPE;
    endcase
    hdr[7:6] = ($urandom_range(0, 3) == 0) ? rsie_pkg::VER_ONE : rsie_pkg::VER_TWO;
    hdr[5] = 1'($urandom_range(0, 1));
    hdr[4:0] = (ptype == rsie_pkg::SDES_TYPE) ? 5'd0 : 5'($urandom_range(0, 31));
    nw = $urandom_range(0, 3);
    dgram_bytes.push_back(hdr);
    dgram_bytes.push_back(ptype);
    dgram_bytes.push_back(8'd0);
    dgram_bytes.push_back(8'(nw));
    repeat (4 * nw) dgram_bytes.push_back(8'($urandom));
  endfunction

  function automatic void build_compound(bit [7:0] want);
    int ilen;
    int words;
    bit [7:0] itype;
    bit [7:0] hdr;
    bit [7:0] body[$];
    dgram_bytes.delete();
    repeat ($urandom_range(0, 2)) add_skip_subpacket();
    repeat (4) body.push_back(8'($urandom));
    repeat ($urandom_range(0, 4)) begin
      itype = $urandom_range(0, 1) ? want : 8'($urandom_range(1, 255));
      ilen = ($urandom_range(0, 19) == 0) ? $urandom_range(13, 255) : $urandom_range(0, 12);
      body.push_back(itype);
      body.push_back(8'(ilen));
      repeat (ilen) body.push_back(8'($urandom));
    end
    if ($urandom_range(0, 4) != 0) body.push_back(rsie_pkg::ITEM_END);
    while (body.size() % 4 != 0) body.push_back(8'h00);
    words = body.size() / 4;
    hdr[7:6] = rsie_pkg::VER_TWO;
    hdr[5] = 1'($urandom_range(0, 1));
    hdr[4:0] = 5'($urandom_range(1, 31));
    dgram_bytes.push_back(hdr);
    dgram_bytes.push_back(rsie_pkg::SDES_TYPE);
    dgram_bytes.push_back(8'(words >> 8));
    dgram_bytes.push_back(8'(words));
    foreach (body[i]) dgram_bytes.push_back(body[i]);
    if ($urandom_range(0, 2) == 0) add_skip_subpacket();
    if ($urandom_range(0, 3) == 0) begin
      dgram_bytes[$urandom_range(0, dgram_bytes.size() - 1)] = 8'($urandom);
    end
  endfunction

  task automatic send_random_datagram();
    int sz;
    len_mode_t mode;
    build_compound(sb.wanted_type);
    sz = dgram_bytes.size();
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4, 5: mode = LEN_EXACT;
      6: mode = LEN_SHORT;
      7: mode = LEN_LONG;
      8: mode = LEN_EARLY_LAST;
      default: mode = $urandom_range(0, 1) ? LEN_TRAILING : LEN_WOBBLE;
    endcase
    case (mode)
      LEN_SHORT: send_datagram($urandom_range(0, sz), sz - 1, 1'b0);
      LEN_LONG: begin
        send_datagram($urandom_range(0, 1) ? sz + $urandom_range(1, 40) :
                      $urandom_range(MAX_BYTES + 1, 8191), sz - 1, 1'b0);
      end
      LEN_EARLY_LAST: send_datagram(sz, $urandom_range(0, sz - 1), 1'b0);
      LEN_TRAILING: begin
        repeat ($urandom_range(1, 6)) dgram_bytes.push_back(8'($urandom));
        send_datagram(sz, dgram_bytes.size() - 1, 1'b0);
      end
      LEN_WOBBLE: send_datagram(sz, sz - 1, 1'b1);
      default: send_datagram(sz, sz - 1, 1'b0);
    endcase
    random_bytes += dgram_bytes.size();
  endtask

  initial begin
    rst_n = 1'b0;
    in_gaps_on = 1'b1;
    out_gaps_on = 1'b1;
    random_bytes = 0;
    in_ch.valid <= 1'b0;
    in_ch.pkt_byte <= 8'd0;
    in_ch.pkt_len <= 13'd0;
    in_ch.byte_last <= 1'b0;
    cfg_ch.valid <= 1'b0;
    cfg_ch.wanted_item_type <= 8'd0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    dgram_bytes = {8'h81, 8'hCA, 8'h00, 8'h02, 8'h11, 8'h22, 8'h33, 8'h44,
                   8'h02, 8'h02, 8'h41, 8'h42};
    send_whole();
    send_datagram(12, 10, 1'b0);
    send_datagram(8191, 11, 1'b0);
    send_datagram(12, 11, 1'b1);
    dgram_bytes.push_back(8'hFF);
    dgram_bytes.push_back(8'h00);
    dgram_bytes.push_back(8'h5A);
    send_datagram(12, 14, 1'b0);

    dgram_bytes = {8'h80, 8'hC9, 8'h00, 8'h00, 8'h41, 8'hCA, 8'h00, 8'h02,
                   8'h55, 8'h66, 8'h77, 8'h88, 8'h01, 8'h00, 8'h02, 8'h00};
    send_whole();
    dgram_bytes = {8'h80, 8'hCA, 8'h00, 8'h01, 8'h00, 8'h00, 8'h00, 8'h00,
                   8'h81, 8'hCA, 8'h00, 8'h03, 8'h01, 8'h02, 8'h03, 8'h04,
                   8'h03, 8'h01, 8'h78, 8'h02, 8'h02, 8'h68, 8'h69, 8'h00};
    send_whole();
    dgram_bytes = {8'h01, 8'hCA, 8'h00, 8'h02, 8'h11, 8'h22, 8'h33, 8'h44,
                   8'h02, 8'h02, 8'h41, 8'h42};
    send_whole();
    dgram_bytes[0] = 8'hC1;
    send_whole();
    dgram_bytes = {8'h81, 8'hCA, 8'h00, 8'h02, 8'h11, 8'h22, 8'h33, 8'h44,
                   8'h00, 8'h02, 8'h61, 8'h00};
    send_whole();
    dgram_bytes[8] = 8'h03;
    dgram_bytes[9] = 8'h09;
    send_whole();
    dgram_bytes[8] = 8'h05;
    dgram_bytes[9] = 8'h02;
    send_whole();
    dgram_bytes = {8'h81, 8'hCA, 8'h00, 8'h05, 8'h11, 8'h22, 8'h33, 8'h44,
                   8'h02, 8'h02, 8'h41, 8'h42};
    send_whole();
    dgram_bytes = {8'h81, 8'hCA, 8'h00, 8'h01, 8'h11, 8'h22, 8'h33, 8'h44};
    send_whole();
    dgram_bytes = {8'h81, 8'hCA, 8'h00, 8'h00};
    send_datagram(3, 3, 1'b0);
    dgram_bytes = {8'h80};
    send_datagram(0, 0, 1'b0);

    write_wanted_type(8'd0);
    dgram_bytes = {8'h80, 8'hC9, 8'h00, 8'h00, 8'h41, 8'hCA, 8'h00, 8'h02,
                   8'h55, 8'h66, 8'h77, 8'h88, 8'h01, 8'h00, 8'h02, 8'h00};
    send_whole();
    dgram_bytes = {8'h81, 8'hCA, 8'h00, 8'h02, 8'h11, 8'h22, 8'h33, 8'h44,
                   8'h00, 8'h02, 8'h61, 8'h00};
    send_whole();

    write_wanted_type(8'd255);
    dgram_bytes = {8'hBF, 8'hCA, 8'h00, 8'h02, 8'hFF, 8'hEE, 8'hDD, 8'hCC,
                   8'hFF, 8'h02, 8'h7E, 8'h80};
    send_whole();

    for (int p = 0; p < RANDOM_PHASES; p++) begin
      case (p % 4)
        0: write_wanted_type(8'($urandom_range(1, 255)));
        1: write_wanted_type(8'd2);
        2: write_wanted_type(8'd255);
        default: write_wanted_type(8'($urandom_range(0, 255)));
      endcase
      random_bytes = 0;
      while (random_bytes < PHASE_BYTES) begin
        in_gaps_on = $urandom_range(0, 3) != 0;
        out_gaps_on = $urandom_range(0, 3) != 0;
        send_random_datagram();
        if ($urandom_range(0, 3) == 0) await_drain();
      end
    end

    @(negedge clk);
    in_ch.valid <= 1'b0;
    while (sb.expected_words.size() != 0) @(posedge clk);
    repeat (END_SETTLE) @(posedge clk);
    if (sb.errors == 0 && sb.expected_words.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end
endmodule

/* files.f */
+incdir+src
src/rsie_pkg.sv
src/rsie_if.sv
src/rsie_parser.sv
src/rsie_out_fifo.sv
src/rtcp_sdes_item_extractor.sv
src/rsie_checker.sv
tb/sv/rtcp_sdes_item_extractor_tb.sv
